FILE: rtl/core/lfp_pkg.sv
// shared types and constants for the lidar frame parser
`default_nettype none
package lfp_pkg;

	localparam int LFP_POINTS_PER_FRAME = 12;
	// byte offset of the first point in a frame
	localparam int LFP_POS_POINTS = 6;
	// end angle, timestamp
	localparam int LFP_TAIL_BYTES = 4;

	localparam logic [1:0] CFG_HEADER = 2'd0;
	localparam logic [1:0] CFG_VERLEN = 2'd1;
	localparam logic [1:0] CFG_POLY   = 2'd2;

	typedef enum logic [1:0] {
		ST_RECV,
		ST_READ,
		ST_LOAD
	} state_t;

	typedef enum logic [3:0] {
		FLD_HDR,
		FLD_VER,
		FLD_TEMP_LO,
		FLD_TEMP_HI,
		FLD_START_LO,
		FLD_START_HI,
		FLD_DIST_LO,
		FLD_DIST_HI,
		FLD_INTEN,
		FLD_END_LO,
		FLD_END_HI,
		FLD_TS_LO,
		FLD_TS_HI,
		FLD_CRC
	} fld_t;

	typedef struct packed {
		logic byte_we;
		fld_t fld;
		logic crc_clr;
		logic good_inc;
		logic mem_rd;
		logic out_load;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic hdr_ok;
		logic ver_ok;
		logic crc_ok;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/lfp_rx_if.sv
// received byte channel
`default_nettype none
interface lfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lfp_pt_if.sv
// point result channel
`default_nettype none
interface lfp_pt_if;
	logic        valid;
	logic        ready;
	logic [3:0]  point_index;
	logic [15:0] point_distance;
	logic [7:0]  point_intensity;
	logic [15:0] frame_temperature;
	logic [15:0] frame_start_angle;
	logic [15:0] frame_end_angle;
	logic [15:0] frame_timestamp;
	logic [15:0] good_frames;
	logic        last_point;

	modport source (
		output valid, output point_index, output point_distance, output point_intensity,
		output frame_temperature, output frame_start_angle, output frame_end_angle,
		output frame_timestamp, output good_frames, output last_point,
		input ready
	);
	modport sink (
		input valid, input point_index, input point_distance, input point_intensity,
		input frame_temperature, input frame_start_angle, input frame_end_angle,
		input frame_timestamp, input good_frames, input last_point,
		output ready
	);
endinterface
`default_nettype wire

FILE: rtl/core/lidar_frame_parser_crc8_core.sv
// Lidar frame parser with CRC-8 check, top level.
// Takes one serial byte per transaction on rx and parses fixed-length frames (header, version,
// temperature, start angle, POINTS_PER_FRAME points of distance and intensity, end angle,
// timestamp, CRC byte; 47 bytes for 12 points). While a frame is being received one byte is
// accepted every cycle. When the CRC byte matches the running CRC-8 (msb first, zero start,
// polynomial from register 2) the points are read back from the point memory and sent on pt,
// each via a registered read (ST_READ) and an output register load (ST_LOAD) that waits while
// pt stalls; rx stays blocked until the last point is loaded. A wrong header or
// version byte, or a bad CRC, returns the parser to waiting for a header with nothing sent.
// Registers: 0 header byte (reset 84), 1 version byte (reset 44), 2 polynomial (reset 77);
// write them only while no frame is in progress.
`default_nettype none
module lidar_frame_parser_crc8_core
	import lfp_pkg::*;
#(
	parameter int POINTS_PER_FRAME = LFP_POINTS_PER_FRAME
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	lfp_rx_if.sink          rx,
	lfp_pt_if.source        pt
);

	localparam int IW = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;

	lfp_ctrl #(
		.POINTS_PER_FRAME(POINTS_PER_FRAME)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.pt_ready (pt.ready),
		.pt_valid (pt.valid),
		.sts      (sts),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	lfp_dp #(
		.POINTS_PER_FRAME(POINTS_PER_FRAME)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.rx_byte           (rx.rx_byte),
		.cmd               (cmd),
		.wr_addr           (wr_addr),
		.rd_addr           (rd_addr),
		.sts               (sts),
		.point_index       (pt.point_index),
		.point_distance    (pt.point_distance),
		.point_intensity   (pt.point_intensity),
		.frame_temperature (pt.frame_temperature),
		.frame_start_angle (pt.frame_start_angle),
		.frame_end_angle   (pt.frame_end_angle),
		.frame_timestamp   (pt.frame_timestamp),
		.good_frames       (pt.good_frames),
		.last_point        (pt.last_point)
	);

	// output register is only overwritten once its transaction is done
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!pt.valid || pt.ready))
		else $error("point output overwritten while pending");

	// no point readout while bytes are being taken
	a_no_load_rx: assert property (@(posedge clk) disable iff (!arst_n)
		rx.ready |-> !cmd.out_load)
		else $error("point load during byte reception");

	// reception resumes right after the last point is loaded
	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.emit_last) |=> rx.ready)
		else $error("reception did not resume after last point");

endmodule
`default_nettype wire

FILE: rtl/core/lfp_ctrl.sv
// frame parser controller: byte position tracking and point readout sequencing
`default_nettype none
module lfp_ctrl
	import lfp_pkg::*;
#(
	parameter int POINTS_PER_FRAME = LFP_POINTS_PER_FRAME,
	localparam int IW = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1,
	localparam int CW = $clog2(POINTS_PER_FRAME + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rx_valid,
	output logic               rx_ready,
	input  wire logic          pt_ready,
	output logic               pt_valid,
	input  wire sts_t          sts,
	output cmd_t               cmd,
	output logic [IW-1:0]      wr_addr,
	output logic [IW-1:0]      rd_addr
);

	localparam int POS_END = LFP_POS_POINTS + 3 * POINTS_PER_FRAME;
	localparam int POS_CRC = POS_END + LFP_TAIL_BYTES;
	localparam int PW = $clog2(POS_CRC + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(POINTS_PER_FRAME - 1);

	state_t         state_q, state_d;
	logic [PW-1:0]  pos_q, pos_d;
	logic [1:0]     phase_q, phase_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [IW-1:0]  emit_q, emit_d;
	logic           out_valid_q;
	fld_t           fld_sel;

	// what the next byte of the frame is
	always_comb begin
		priority if (pos_q == PW'(0)) begin
			fld_sel = FLD_HDR;
		end else if (pos_q == PW'(1)) begin
			fld_sel = FLD_VER;
		end else if (pos_q == PW'(2)) begin
			fld_sel = FLD_TEMP_LO;
		end else if (pos_q == PW'(3)) begin
			fld_sel = FLD_TEMP_HI;
		end else if (pos_q == PW'(4)) begin
			fld_sel = FLD_START_LO;
		end else if (pos_q == PW'(5)) begin
			fld_sel = FLD_START_HI;
		end else if (pos_q < PW'(POS_END)) begin
			unique case (phase_q)
				2'd0:    fld_sel = FLD_DIST_LO;
				2'd1:    fld_sel = FLD_DIST_HI;
				default: fld_sel = FLD_INTEN;
			endcase
		end else if (pos_q == PW'(POS_END)) begin
			fld_sel = FLD_END_LO;
		end else if (pos_q == PW'(POS_END + 1)) begin
			fld_sel = FLD_END_HI;
		end else if (pos_q == PW'(POS_END + 2)) begin
			fld_sel = FLD_TS_LO;
		end else if (pos_q == PW'(POS_END + 3)) begin
			fld_sel = FLD_TS_HI;
		end else begin
			fld_sel = FLD_CRC;
		end
	end

	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		emit_d   = emit_q;
		rx_ready = 1'b0;
		cmd      = '0;
		cmd.fld  = fld_sel;
		unique case (state_q)
			ST_RECV: begin
				rx_ready = 1'b1;
				if (rx_valid) begin
					cmd.byte_we = 1'b1;
					pos_d = pos_q + PW'(1);
					unique case (fld_sel)
						FLD_HDR: begin
							if (!sts.hdr_ok) begin
								cmd.crc_clr = 1'b1;
								pos_d = '0;
							end
						end
						FLD_VER: begin
							phase_d = '0;
							cnt_d   = '0;
							if (!sts.ver_ok) begin
								cmd.crc_clr = 1'b1;
								pos_d = '0;
							end
						end
						FLD_DIST_LO: phase_d = 2'd1;
						FLD_DIST_HI: phase_d = 2'd2;
						FLD_INTEN: begin
							phase_d = 2'd0;
							cnt_d = cnt_q + CW'(1);
						end
						FLD_CRC: begin
							cmd.crc_clr = 1'b1;
							pos_d = '0;
							cnt_d = '0;
							if (sts.crc_ok) begin
								cmd.good_inc = 1'b1;
								emit_d = '0;
								state_d = ST_READ;
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.emit_last = (emit_q == LAST_IDX);
				if (!out_valid_q || pt_ready) begin
					cmd.out_load = 1'b1;
					if (emit_q == LAST_IDX) begin
						state_d = ST_RECV;
					end else begin
						emit_d = emit_q + IW'(1);
						state_d = ST_READ;
					end
				end
			end
			default: state_d = ST_RECV;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RECV;
			pos_q       <= '0;
			phase_q     <= '0;
			cnt_q       <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			emit_q  <= emit_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (pt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pt_valid = out_valid_q;
	assign wr_addr  = cnt_q[IW-1:0];
	assign rd_addr  = emit_q;

endmodule
`default_nettype wire

FILE: rtl/core/lfp_dp.sv
// frame parser datapath: config registers, crc, frame words, point memory, output register
`default_nettype none
module lfp_dp
	import lfp_pkg::*;
#(
	parameter int POINTS_PER_FRAME = LFP_POINTS_PER_FRAME,
	localparam int IW = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	input  wire logic [7:0]    rx_byte,
	input  wire cmd_t          cmd,
	input  wire logic [IW-1:0] wr_addr,
	input  wire logic [IW-1:0] rd_addr,
	output sts_t               sts,
	output logic [3:0]         point_index,
	output logic [15:0]        point_distance,
	output logic [7:0]         point_intensity,
	output logic [15:0]        frame_temperature,
	output logic [15:0]        frame_start_angle,
	output logic [15:0]        frame_end_angle,
	output logic [15:0]        frame_timestamp,
	output logic [15:0]        good_frames,
	output logic               last_point
);

	logic [7:0]  hdr_q, ver_q, poly_q;
	logic [7:0]  crc_q;
	logic [15:0] good_q;
	logic [15:0] temp_q, start_q, end_q, ts_q, dist_q;
	logic [23:0] mem [POINTS_PER_FRAME];
	logic [23:0] rd_data_s1;

	// msb-first crc-8, no reflection
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	assign sts.hdr_ok = (rx_byte == hdr_q);
	assign sts.ver_ok = (rx_byte == ver_q);
	assign sts.crc_ok = (rx_byte == crc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= 8'd84;
			ver_q  <= 8'd44;
			poly_q <= 8'd77;
			crc_q  <= '0;
			good_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEADER: hdr_q  <= cfg_data;
					CFG_VERLEN: ver_q  <= cfg_data;
					CFG_POLY:   poly_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.crc_clr) begin
				crc_q <= '0;
			end else if (cmd.byte_we) begin
				crc_q <= crc8_step(crc_q, rx_byte, poly_q);
			end
			if (cmd.good_inc) begin
				good_q <= good_q + 16'd1;
			end
		end
	end

	// frame words, little-endian
	always_ff @(posedge clk) begin
		if (cmd.byte_we) begin
			unique case (cmd.fld)
				FLD_TEMP_LO:  temp_q[7:0]   <= rx_byte;
				FLD_TEMP_HI:  temp_q[15:8]  <= rx_byte;
				FLD_START_LO: start_q[7:0]  <= rx_byte;
				FLD_START_HI: start_q[15:8] <= rx_byte;
				FLD_DIST_LO:  dist_q[7:0]   <= rx_byte;
				FLD_DIST_HI:  dist_q[15:8]  <= rx_byte;
				FLD_END_LO:   end_q[7:0]    <= rx_byte;
				FLD_END_HI:   end_q[15:8]   <= rx_byte;
				FLD_TS_LO:    ts_q[7:0]     <= rx_byte;
				FLD_TS_HI:    ts_q[15:8]    <= rx_byte;
				default: ;
			endcase
		end
	end

	// point memory: whole entry written on the intensity byte
	always_ff @(posedge clk) begin
		if (cmd.byte_we && cmd.fld == FLD_INTEN) begin
			mem[wr_addr] <= {rx_byte, dist_q};
		end
		if (cmd.mem_rd) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			point_index       <= 4'(rd_addr);
			point_distance    <= rd_data_s1[15:0];
			point_intensity   <= rd_data_s1[23:16];
			frame_temperature <= temp_q;
			frame_start_angle <= start_q;
			frame_end_angle   <= end_q;
			frame_timestamp   <= ts_q;
			good_frames       <= good_q;
			last_point        <= cmd.emit_last;
		end
	end

endmodule
`default_nettype wire

FILE: bench/lidar_frame_parser_crc8_core_tb.sv
// testbench for the lidar frame parser: byte driver, point checker and crc-8 predictor
module lidar_frame_parser_crc8_core_tb;
	import lfp_pkg::*;

	localparam int POS_END_ANGLE = LFP_POS_POINTS + 3 * LFP_POINTS_PER_FRAME;
	localparam int POS_CRC = POS_END_ANGLE + LFP_TAIL_BYTES;
	// bytes between the version byte and the crc byte
	localparam int BODY_BYTES = POS_CRC - 2;
	localparam logic [7:0] RST_HEADER = 8'd84;
	localparam logic [7:0] RST_VERLEN = 8'd44;
	localparam logic [7:0] RST_POLY = 8'd77;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int TARGET_BYTES = 470;
	localparam int TARGET_POINTS = 48;
	localparam int PHASE_BYTES = 60;
	localparam int EMIT_WAIT = 2 * LFP_POINTS_PER_FRAME + 16;

	typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_VER, FRAME_SHORT} frame_kind_t;

	typedef struct packed {
		logic [3:0]  num;
		logic [15:0] distance;
		logic [7:0]  intensity;
		logic [15:0] temperature;
		logic [15:0] angle_from;
		logic [15:0] angle_to;
		logic [15:0] timestamp;
		logic [15:0] good;
		logic        last;
	} point_t;

	class point_scoreboard;
		logic [7:0]  hdr_byte;
		logic [7:0]  ver_byte;
		logic [7:0]  poly;
		int unsigned frame_pos;
		logic [7:0]  crc_acc;
		logic [23:0] store[LFP_POINTS_PER_FRAME];
		int unsigned slot;
		logic [15:0] temp_w;
		logic [15:0] start_w;
		logic [15:0] end_w;
		logic [15:0] ts_w;
		logic [15:0] good_cnt;
		point_t      expected_points[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			hdr_byte = RST_HEADER;
			ver_byte = RST_VERLEN;
			poly = RST_POLY;
			good_cnt = '0;
			errors = 0;
			checked = 0;
			go_idle();
		endfunction

		function void go_idle();
			frame_pos = 0;
			crc_acc = '0;
			slot = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] v);
			case (idx)
				CFG_HEADER: hdr_byte = v;
				CFG_VERLEN: ver_byte = v;
				CFG_POLY: poly = v;
				default: ;
			endcase
		endfunction

		function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
			logic [7:0] r;
			r = c ^ b;
			for (int i = 0; i < 8; i++)
				r = r[7] ? ((r << 1) ^ poly) : (r << 1);
			return r;
		endfunction

		function void note_byte(logic [7:0] b);
			point_t p;
			int unsigned phase;
			if (frame_pos == POS_CRC) begin
				if (b == crc_acc) begin
					good_cnt = good_cnt + 16'd1;
					for (int k = 0; k < LFP_POINTS_PER_FRAME; k++) begin
						p.num = 4'(k);
						p.distance = store[k][15:0];
						p.intensity = store[k][23:16];
						p.temperature = temp_w;
						p.angle_from = start_w;
						p.angle_to = end_w;
						p.timestamp = ts_w;
						p.good = good_cnt;
						p.last = (k == LFP_POINTS_PER_FRAME - 1);
						expected_points.push_back(p);
					end
				end
				go_idle();
				return;
			end
			if (frame_pos == 0) begin
				if (b != hdr_byte) begin
					go_idle();
					return;
				end
			end else if (frame_pos == 1) begin
				// a wrong version byte is not retried as a header
				if (b != ver_byte) begin
					go_idle();
					return;
				end
			end else if (frame_pos == 2) begin
				temp_w = {8'h00, b};
			end else if (frame_pos == 3) begin
				temp_w[15:8] = b;
			end else if (frame_pos == 4) begin
				start_w = {8'h00, b};
			end else if (frame_pos == 5) begin
				start_w[15:8] = b;
			end else if (frame_pos < POS_END_ANGLE) begin
				phase = (frame_pos - LFP_POS_POINTS) % 3;
				if (phase == 0) begin
					store[slot][7:0] = b;
				end else if (phase == 1) begin
					store[slot][15:8] = b;
				end else begin
					store[slot][23:16] = b;
					slot++;
				end
			end else if (frame_pos == POS_END_ANGLE) begin
				end_w = {8'h00, b};
			end else if (frame_pos == POS_END_ANGLE + 1) begin
				end_w[15:8] = b;
			end else if (frame_pos == POS_END_ANGLE + 2) begin
				ts_w = {8'h00, b};
			end else begin
				ts_w[15:8] = b;
			end
			crc_acc = crc_step(crc_acc, b);
			frame_pos++;
		endfunction

		function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
			if (got_v !== exp_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_point(point_t got);
			point_t e;
			if (expected_points.size() == 0) begin
				$error("point result with nothing expected: index %0d", got.num);
				errors++;
				return;
			end
			e = expected_points.pop_front();
			checked++;
			cmp_field("point_index", 16'(e.num), 16'(got.num));
			cmp_field("point_distance", e.distance, got.distance);
			cmp_field("point_intensity", 16'(e.intensity), 16'(got.intensity));
			cmp_field("frame_temperature", e.temperature, got.temperature);
			cmp_field("frame_start_angle", e.angle_from, got.angle_from);
			cmp_field("frame_end_angle", e.angle_to, got.angle_to);
			cmp_field("frame_timestamp", e.timestamp, got.timestamp);
			cmp_field("good_frames", e.good, got.good);
			cmp_field("last_point", 16'(e.last), 16'(got.last));
		endfunction

		function int unsigned pending();
			return expected_points.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	lfp_rx_if rx_ch();
	lfp_pt_if pt_ch();

	point_scoreboard sb = new();

	bit source_quiet;
	bit sink_quiet;
	int hold_cycles;
	int bytes_sent;

	lidar_frame_parser_crc8_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rx(rx_ch),
		.pt(pt_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("lidar_frame_parser_crc8_core_tb: done, errors");
		$finish;
	end

	// point receiver: random stalls, quiet stretches and one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				pt_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (sink_quiet) begin
				pt_ch.ready <= 1'b1;
			end else begin
				pt_ch.ready <= ($urandom_range(99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		point_t got;
		if (arst_n && pt_ch.valid && pt_ch.ready) begin
			got.num = pt_ch.point_index;
			got.distance = pt_ch.point_distance;
			got.intensity = pt_ch.point_intensity;
			got.temperature = pt_ch.frame_temperature;
			got.angle_from = pt_ch.frame_start_angle;
			got.angle_to = pt_ch.frame_end_angle;
			got.timestamp = pt_ch.frame_timestamp;
			got.good = pt_ch.good_frames;
			got.last = pt_ch.last_point;
			sb.check_point(got);
		end
	end

	// entered and left at a falling edge; valid stays up for a following byte
	task automatic send_byte(input logic [7:0] b);
		if (!source_quiet) begin
			while ($urandom_range(99) < 16) begin
				rx_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		sb.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input frame_kind_t kind, input int fill);
		int body;
		send_byte(sb.hdr_byte);
		if (kind == FRAME_BAD_VER) begin
			send_byte(sb.ver_byte ^ 8'($urandom_range(1, 255)));
			return;
		end
		send_byte(sb.ver_byte);
		body = (kind == FRAME_SHORT) ? $urandom_range(1, BODY_BYTES - 1) : BODY_BYTES;
		for (int i = 0; i < body; i++)
			send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
		if (kind == FRAME_SHORT)
			return;
		if (kind == FRAME_GOOD)
			send_byte(sb.crc_acc);
		else
			send_byte(sb.crc_acc ^ 8'($urandom_range(1, 255)));
	endtask

	// finish off a partial frame so registers can be rewritten
	task automatic return_to_idle();
		while (sb.frame_pos != 0) begin
			if (sb.frame_pos == 1)
				send_byte(~sb.ver_byte);
			else if (sb.frame_pos == POS_CRC)
				send_byte(sb.crc_acc ^ 8'h01);
			else
				send_byte(8'($urandom));
		end
	endtask

	task automatic drain();
		rx_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (EMIT_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic program_phase(input int phase);
		case (phase)
			0: begin
				write_reg(CFG_HEADER, 8'h00);
				write_reg(CFG_VERLEN, 8'h00);
				write_reg(CFG_POLY, 8'h00);
			end
			1: begin
				write_reg(CFG_HEADER, 8'hff);
				write_reg(CFG_VERLEN, 8'hff);
				write_reg(CFG_POLY, 8'hff);
			end
			3: begin
				write_reg(CFG_HEADER, RST_HEADER);
				write_reg(CFG_VERLEN, RST_VERLEN);
				write_reg(CFG_POLY, 8'h07);
				// no register behind this index
				write_reg(CFG_UNUSED, 8'($urandom));
			end
			default: begin
				write_reg(CFG_HEADER, 8'($urandom));
				write_reg(CFG_VERLEN, 8'($urandom));
				write_reg(CFG_POLY, 8'($urandom));
			end
		endcase
	endtask

	task automatic send_random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			send_frame(FRAME_GOOD, -1);
		end else if (pick < 80) begin
			send_frame(FRAME_BAD_CRC, -1);
		end else if (pick < 87) begin
			send_frame(FRAME_BAD_VER, -1);
		end else if (pick < 94) begin
			send_frame(FRAME_SHORT, -1);
		end else begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end
	endtask

	initial begin
		int phase;
		int phase_start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		pt_ch.ready = 1'b0;
		source_quiet = 1'b0;
		sink_quiet = 1'b0;
		hold_cycles = 0;
		bytes_sent = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray bytes while waiting for a header
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(RST_VERLEN);
		// header twice: the second one is a bad version byte, then the version is dropped
		send_byte(RST_HEADER);
		send_byte(RST_HEADER);
		send_byte(RST_VERLEN);
		send_frame(FRAME_GOOD, 8'h00);
		send_frame(FRAME_GOOD, 8'hff);
		send_frame(FRAME_BAD_CRC, -1);
		send_frame(FRAME_BAD_VER, -1);
		send_frame(FRAME_GOOD, -1);

		for (phase = 0; bytes_sent < TARGET_BYTES || sb.checked < TARGET_POINTS; phase++) begin
			return_to_idle();
			drain();
			program_phase(phase);
			source_quiet = (phase == 1);
			sink_quiet = (phase == 1);
			// point side blocked while bytes keep coming, so the parser backs up
			if (phase == 0)
				hold_cycles = 300;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_random_sequence();
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("lidar_frame_parser_crc8_core_tb: done, clean");
		else
			$display("lidar_frame_parser_crc8_core_tb: done, errors");
		$finish;
	end

endmodule

FILE: lidar_frame_parser_crc8_core.f
rtl/core/lfp_pkg.sv
rtl/core/lfp_rx_if.sv
rtl/core/lfp_pt_if.sv
rtl/core/lfp_ctrl.sv
rtl/core/lfp_dp.sv
rtl/core/lidar_frame_parser_crc8_core.sv
bench/lidar_frame_parser_crc8_core_tb.sv
